### hw/rtl/pulse_run_merger_core_assert.svh
// Assertion macros shared by the pulse run merger RTL.
`ifndef PULSE_RUN_MERGER_CORE_ASSERT_SVH
`define PULSE_RUN_MERGER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PRM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define PRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/prm_pkg.sv
// Shared types and constants of the pulse run merger.
package prm_pkg;

   localparam int TICK_WIDTH = 15;
   localparam int RUN_W      = 32;
   localparam int DIVD_W     = RUN_W + 4;           // run_ticks * 10
   localparam int DIVS_W     = 10;
   localparam int DIV_CNT_W  = $clog2(DIVD_W);
   localparam int IDLE_W     = 16;
   localparam int PULSE_W    = 32;
   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 32;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_TICKS    = 2'd0;
   localparam logic [1:0] REG_INVERTED = 2'd1;
   localparam logic [1:0] REG_IDLE     = 2'd2;

   localparam logic [DIVS_W-1:0] TICKS_RESET = 10'd10;
   localparam logic [IDLE_W-1:0] IDLE_RESET  = 16'd10000;

   localparam logic [DIVD_W-1:0]  US_MAX     = DIVD_W'(32'h7FFF_FFFF);
   localparam logic [PULSE_W-2:0] US_MAX_MAG = '1;

   // which part of the item the sequencer is working on
   localparam logic [1:0] STEP_FIRST  = 2'd0;
   localparam logic [1:0] STEP_SECOND = 2'd1;
   localparam logic [1:0] STEP_FLUSH  = 2'd2;

   typedef logic [TICK_WIDTH-1:0] ticks_type;

   typedef struct packed {
      logic [DIVS_W-1:0] ticks_per_ten_us;
      logic              inverted;
      logic [IDLE_W-1:0] idle_us;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DIVD_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HALF,
      ST_FLUSH,
      ST_DIV,
      ST_PUSH_RUN,
      ST_TAIL,
      ST_PUSH_IDLE
   } state_type;

endpackage

### hw/rtl/prm_channels_if.sv
// Valid/ready channel interfaces for items and results.
interface prm_req_if;
   logic                valid;
   logic                ready;
   logic                first_level;
   prm_pkg::ticks_type  first_ticks;
   logic                second_level;
   prm_pkg::ticks_type  second_ticks;
   logic                end_of_buffer;

   modport source (output valid, first_level, first_ticks, second_level, second_ticks,
                   end_of_buffer, input ready);
   modport sink   (input valid, first_level, first_ticks, second_level, second_ticks,
                   end_of_buffer, output ready);
endinterface

interface prm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [prm_pkg::PULSE_W-1:0]  pulse_us;
   logic                                frame_done;

   modport source (output valid, pulse_us, frame_done, input ready);
   modport sink   (input valid, pulse_us, frame_done, output ready);
endinterface

### hw/rtl/prm_csr.sv
// APB-style configuration registers of the pulse run merger.
module prm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [prm_pkg::ADDR_W-1:0]    paddr,
   input  logic [prm_pkg::DATA_W-1:0]    pwdata,
   output logic [prm_pkg::DATA_W-1:0]    prdata,
   output logic                          pready,
   output prm_pkg::cfg_type              cfg
);

   logic [prm_pkg::DIVS_W-1:0] ticks_ff, ticks_in;
   logic                       inv_ff, inv_in;
   logic [prm_pkg::IDLE_W-1:0] idle_ff, idle_in;
   logic                       wr_en;
   logic [1:0]                 reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      ticks_in = ticks_ff;
      inv_in   = inv_ff;
      idle_in  = idle_ff;
      if (wr_en) begin
         unique case (reg_idx)
            prm_pkg::REG_TICKS:    ticks_in = pwdata[prm_pkg::DIVS_W-1:0];
            prm_pkg::REG_INVERTED: inv_in   = pwdata[0];
            prm_pkg::REG_IDLE:     idle_in  = pwdata[prm_pkg::IDLE_W-1:0];
            default: ;             // unmapped: write dropped
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         prm_pkg::REG_TICKS:
            prdata = {{(prm_pkg::DATA_W-prm_pkg::DIVS_W){1'b0}}, ticks_ff};
         prm_pkg::REG_INVERTED:
            prdata = {{(prm_pkg::DATA_W-1){1'b0}}, inv_ff};
         prm_pkg::REG_IDLE:
            prdata = {{(prm_pkg::DATA_W-prm_pkg::IDLE_W){1'b0}}, idle_ff};
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= prm_pkg::TICKS_RESET;
         inv_ff   <= 1'b0;
         idle_ff  <= prm_pkg::IDLE_RESET;
      end else begin
         ticks_ff <= ticks_in;
         inv_ff   <= inv_in;
         idle_ff  <= idle_in;
      end
   end

   assign cfg.ticks_per_ten_us = ticks_ff;
   assign cfg.inverted         = inv_ff;
   assign cfg.idle_us          = idle_ff;

endmodule

### hw/rtl/prm_div.sv
// Restoring divider, one quotient bit per cycle.
module prm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  prm_pkg::div_req_type req,
   output prm_pkg::div_rsp_type rsp
);

   localparam logic [prm_pkg::DIV_CNT_W-1:0] CNT_LAST =
      prm_pkg::DIV_CNT_W'(prm_pkg::DIVD_W - 1);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [prm_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [prm_pkg::DIVS_W-1:0]        rem_ff, rem_in;
   logic [prm_pkg::DIVS_W-1:0]        dvs_ff, dvs_in;
   logic [prm_pkg::DIVD_W-1:0]        quo_ff, quo_in;
   logic [prm_pkg::DIVS_W:0]          shifted;
   logic [prm_pkg::DIVS_W+1:0]        trial;
   logic                              fits;

   // partial remainder stays below the divisor, so DIVS_W bits hold it
   assign shifted = {rem_ff, quo_ff[prm_pkg::DIVD_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dvs_ff};
   assign fits    = ~trial[prm_pkg::DIVS_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = (req.divisor == '0) ? prm_pkg::DIVS_W'(1) : req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial[prm_pkg::DIVS_W-1:0] : shifted[prm_pkg::DIVS_W-1:0];
         quo_in = {quo_ff[prm_pkg::DIVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

### hw/rtl/pulse_run_merger_core.sv
// Pulse run merger top level: sequencer, run state and result register.
//
// Merges receiver items (two level/tick halves each) into runs and reports each finished
// run as a signed duration in microseconds: ticks*10/ticks_per_ten_us, saturated to
// 2^31-1, positive for high and negative for low (sign flipped when inverted is set).
// An item with end_of_buffer flushes the open run; a buffer that produced any result
// is closed by -idle_us with frame_done set. Items are taken one at a time: req ready
// is high only while the sequencer is idle and out of reset. An item takes its halves in
// turn, then the flush and tail on end of buffer, then the idle result when it goes out,
// plus a conversion for each run it closes (at most three): every conversion goes through
// one shared restoring divider that produces one quotient bit per cycle over the 36-bit
// dividend, and the result register is loaded once the divide state ends. A stalled
// receiver adds its stall to each result push. Results leave through an output register,
// so the divider keeps working while a result waits to be taken. No clearing pass after
// reset.
`include "pulse_run_merger_core_assert.svh"

module pulse_run_merger_core (
   input  logic                       clock,
   input  logic                       reset,
   prm_req_if.sink                    req_bus,
   prm_rsp_if.source                  rsp_bus,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [prm_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [prm_pkg::DATA_W-1:0] csr_pwdata,
   output logic [prm_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   prm_pkg::cfg_type     cfg;
   prm_pkg::div_req_type div_req;
   prm_pkg::div_rsp_type div_rsp;

   prm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   prm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // ---- state ----
   prm_pkg::state_type          state_ff, state_in;
   logic [1:0]                  step_ff, step_in;
   logic                        run_level_ff, run_level_in;
   logic [prm_pkg::RUN_W-1:0]   run_ticks_ff, run_ticks_in;
   logic                        emitted_ff, emitted_in;
   logic                        pend_level_ff, pend_level_in;   // level of run in divider
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [prm_pkg::PULSE_W-1:0] rsp_pulse_ff, rsp_pulse_in;
   logic                        rsp_done_ff, rsp_done_in;

   // latched item
   logic                first_level_ff, second_level_ff, eob_ff;
   prm_pkg::ticks_type  first_ticks_ff, second_ticks_ff;

   // ---- datapath helpers ----
   logic                        req_xfer;
   logic                        out_free;
   logic                        cur_level;
   prm_pkg::ticks_type          cur_ticks;
   logic                        half_live;      // nonzero half
   logic                        half_closes;    // closes a nonempty run
   logic [prm_pkg::RUN_W:0]     run_sum;
   logic [prm_pkg::RUN_W-1:0]   run_sum_sat;
   logic [prm_pkg::PULSE_W-1:0] run_mag;
   logic [prm_pkg::PULSE_W-1:0] run_value;
   logic [prm_pkg::PULSE_W-1:0] idle_value;
   prm_pkg::state_type          after_half;

   assign req_bus.ready = (state_ff == prm_pkg::ST_IDLE) & ~reset;
   assign req_xfer      = req_bus.valid & req_bus.ready;
   assign out_free      = ~rsp_valid_ff | rsp_bus.ready;

   assign cur_level   = (step_ff == prm_pkg::STEP_SECOND) ? second_level_ff : first_level_ff;
   assign cur_ticks   = (step_ff == prm_pkg::STEP_SECOND) ? second_ticks_ff : first_ticks_ff;
   assign half_live   = (cur_ticks != '0);
   assign half_closes = half_live & (cur_level != run_level_ff) & (run_ticks_ff != '0);

   // same-level half: saturating add to the open run
   assign run_sum     = {1'b0, run_ticks_ff}
                      + {{(prm_pkg::RUN_W+1-prm_pkg::TICK_WIDTH){1'b0}}, cur_ticks};
   assign run_sum_sat = run_sum[prm_pkg::RUN_W] ? '1 : run_sum[prm_pkg::RUN_W-1:0];

   // divider quotient -> clamped magnitude -> signed value
   assign run_mag   = (div_rsp.quotient > prm_pkg::US_MAX)
                    ? {1'b0, prm_pkg::US_MAX_MAG}
                    : {1'b0, div_rsp.quotient[prm_pkg::PULSE_W-2:0]};
   assign run_value = (pend_level_ff ^ cfg.inverted) ? run_mag : (~run_mag + 1'b1);
   assign idle_value = ~{{(prm_pkg::PULSE_W-prm_pkg::IDLE_W){1'b0}}, cfg.idle_us} + 1'b1;

   // where to go once the current half is fully handled
   always_comb begin
      priority if (step_ff == prm_pkg::STEP_FIRST) begin
         after_half = prm_pkg::ST_HALF;
      end else if (eob_ff) begin
         after_half = prm_pkg::ST_FLUSH;
      end else begin
         after_half = prm_pkg::ST_IDLE;
      end
   end

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prm_pkg::ST_IDLE:
            if (req_xfer) state_in = prm_pkg::ST_HALF;
         prm_pkg::ST_HALF:
            state_in = half_closes ? prm_pkg::ST_DIV : after_half;
         prm_pkg::ST_FLUSH:
            state_in = (run_ticks_ff != '0) ? prm_pkg::ST_DIV : prm_pkg::ST_TAIL;
         prm_pkg::ST_DIV:
            if (div_rsp.done) state_in = prm_pkg::ST_PUSH_RUN;
         prm_pkg::ST_PUSH_RUN:
            if (out_free) begin
               state_in = (step_ff == prm_pkg::STEP_FLUSH) ? prm_pkg::ST_TAIL : after_half;
            end
         prm_pkg::ST_TAIL:
            state_in = emitted_ff ? prm_pkg::ST_PUSH_IDLE : prm_pkg::ST_IDLE;
         prm_pkg::ST_PUSH_IDLE:
            if (out_free) state_in = prm_pkg::ST_IDLE;
         default:
            state_in = prm_pkg::ST_IDLE;
      endcase
   end

   // ---- outputs and run-state updates ----
   always_comb begin
      step_in          = step_ff;
      run_level_in     = run_level_ff;
      run_ticks_in     = run_ticks_ff;
      emitted_in       = emitted_ff;
      pend_level_in    = pend_level_ff;
      rsp_valid_in     = rsp_valid_ff & ~rsp_bus.ready;
      rsp_pulse_in     = rsp_pulse_ff;
      rsp_done_in      = rsp_done_ff;
      div_req.start    = 1'b0;
      // dividend = run_ticks * 10 as shift-add
      div_req.dividend = {1'b0, run_ticks_ff, 3'b000} + {3'b000, run_ticks_ff, 1'b0};
      div_req.divisor  = cfg.ticks_per_ten_us;

      unique case (state_ff)
         prm_pkg::ST_IDLE:
            if (req_xfer) step_in = prm_pkg::STEP_FIRST;
         prm_pkg::ST_HALF: begin
            if (half_live) begin
               if (cur_level == run_level_ff) begin
                  run_ticks_in = run_sum_sat;
               end else begin
                  // old run goes to the divider, the half opens a new one
                  if (run_ticks_ff != '0) begin
                     div_req.start = 1'b1;
                     pend_level_in = run_level_ff;
                  end
                  run_level_in = cur_level;
                  run_ticks_in = {{(prm_pkg::RUN_W-prm_pkg::TICK_WIDTH){1'b0}}, cur_ticks};
               end
            end
            if (!half_closes && step_ff == prm_pkg::STEP_FIRST) step_in = prm_pkg::STEP_SECOND;
         end
         prm_pkg::ST_FLUSH: begin
            step_in = prm_pkg::STEP_FLUSH;
            if (run_ticks_ff != '0) begin
               div_req.start = 1'b1;
               pend_level_in = run_level_ff;
            end
         end
         prm_pkg::ST_DIV: ;
         prm_pkg::ST_PUSH_RUN:
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pulse_in = run_value;
               rsp_done_in  = 1'b0;
               emitted_in   = 1'b1;
               if (step_ff == prm_pkg::STEP_FIRST) step_in = prm_pkg::STEP_SECOND;
            end
         prm_pkg::ST_TAIL:
            if (!emitted_ff) begin
               run_level_in = 1'b0;
               run_ticks_in = '0;
            end
         prm_pkg::ST_PUSH_IDLE:
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pulse_in = idle_value;
               rsp_done_in  = 1'b1;
               run_level_in = 1'b0;
               run_ticks_in = '0;
               emitted_in   = 1'b0;
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prm_pkg::ST_IDLE;
         step_ff      <= prm_pkg::STEP_FIRST;
         run_level_ff <= 1'b0;
         run_ticks_ff <= '0;
         emitted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         run_level_ff <= run_level_in;
         run_ticks_ff <= run_ticks_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      pend_level_ff <= pend_level_in;
      rsp_pulse_ff  <= rsp_pulse_in;
      rsp_done_ff   <= rsp_done_in;
      if (req_xfer) begin
         first_level_ff  <= req_bus.first_level;
         first_ticks_ff  <= req_bus.first_ticks;
         second_level_ff <= req_bus.second_level;
         second_ticks_ff <= req_bus.second_ticks;
         eob_ff          <= req_bus.end_of_buffer;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.pulse_us   = rsp_pulse_ff;
   assign rsp_bus.frame_done = rsp_done_ff;

   // ---- checks ----
   `PRM_ASSERT_IMPL(a_div_start_free, clock, reset, div_req.start, !div_rsp.busy,
                    "divider started while busy")
   `PRM_ASSERT_IMPL(a_idle_needs_emit, clock, reset, state_ff == prm_pkg::ST_PUSH_IDLE,
                    emitted_ff, "idle result pending for a buffer with no run")
   `PRM_ASSERT_IMPL(a_no_xfer_mid_div, clock, reset, req_xfer, !div_rsp.busy,
                    "item transfer while a conversion is running")
   `PRM_ASSERT_NEXT(a_idle_clears_run, clock, reset,
                    state_ff == prm_pkg::ST_PUSH_IDLE && out_free,
                    run_ticks_ff == '0 && !emitted_ff && !run_level_ff,
                    "run state not cleared after buffer close")

endmodule

### verif/tb_pulse_run_merger_core.sv
// Self-checking testbench for pulse_run_merger_core: random and directed items, scoreboarded.
module tb_pulse_run_merger_core;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 7;
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int DRAIN_CYCLES = 300;      // well past the worst case per item
   localparam int HOLD_CYCLES  = 600;      // long receiver hold-off for the backpressure phase

   // byte address 12 decodes to no register; writes there must be dropped
   localparam logic [1:0] REG_UNUSED = 2'd3;

   localparam prm_pkg::ticks_type TICKS_MAX = '1;

   typedef struct {
      logic               first_level;
      prm_pkg::ticks_type first_ticks;
      logic               second_level;
      prm_pkg::ticks_type second_ticks;
      logic               end_of_buffer;
   } halves_item_type;

   typedef struct {
      logic signed [prm_pkg::PULSE_W-1:0] pulse_us;
      logic                               frame_done;
   } pulse_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       csr_psel    = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite  = 1'b0;
   logic [prm_pkg::ADDR_W-1:0] csr_paddr   = '0;
   logic [prm_pkg::DATA_W-1:0] csr_pwdata  = '0;
   logic [prm_pkg::DATA_W-1:0] csr_prdata;
   logic                       csr_pready;

   prm_req_if req_if ();
   prm_rsp_if rsp_if ();

   pulse_run_merger_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Traffic knobs, set from the sequence at a falling edge only
   // ---------------------------------------------------------------------------------
   int   sender_idle_pct = 0;
   int   recv_stall_pct  = 0;
   logic hold_go         = 1'b0;

   halves_item_type item_backlog[$];       // items waiting to be offered
   pulse_type       expected_pulses[$];    // predicted results, oldest first
   int              mismatch_count = 0;

   // ---------------------------------------------------------------------------------
   // Shadow of the block: registers and the open run
   // ---------------------------------------------------------------------------------
   logic [prm_pkg::DIVS_W-1:0] cfg_ticks_per_ten_us = prm_pkg::TICKS_RESET;
   logic                       cfg_inverted         = 1'b0;
   logic [prm_pkg::IDLE_W-1:0] cfg_idle_us          = prm_pkg::IDLE_RESET;

   logic                      run_level      = 1'b0;
   logic [prm_pkg::RUN_W-1:0] run_ticks      = '0;
   logic                      buffer_emitted = 1'b0;

   // ticks*10/divisor in 64 bits, clipped to the largest positive pulse; divisor 0 acts as 1
   function automatic logic [prm_pkg::PULSE_W-1:0] ticks_to_us(
         input logic [prm_pkg::RUN_W-1:0] ticks);
      logic [63:0] divisor;
      logic [63:0] quotient;
      divisor  = (cfg_ticks_per_ten_us == '0) ? 64'd1 : 64'(cfg_ticks_per_ten_us);
      quotient = (64'(ticks) * 64'd10) / divisor;
      if (quotient > 64'h7FFF_FFFF)
         quotient = 64'h7FFF_FFFF;
      return quotient[prm_pkg::PULSE_W-1:0];
   endfunction

   task automatic close_run();
      pulse_type                   res;
      logic [prm_pkg::PULSE_W-1:0] mag;
      mag            = ticks_to_us(run_ticks);
      // high is positive unless the pin is inverted
      res.pulse_us   = (run_level ^ cfg_inverted) ? mag : (32'd0 - mag);
      res.frame_done = 1'b0;
      expected_pulses.insert(expected_pulses.size(), res);
      buffer_emitted = 1'b1;
   endtask

   task automatic merge_half(input logic level, input prm_pkg::ticks_type ticks);
      logic [prm_pkg::RUN_W:0] sum;
      if (ticks == '0)
         return;                           // absent half
      if (level == run_level) begin
         sum       = {1'b0, run_ticks} + (prm_pkg::RUN_W+1)'(ticks);
         run_ticks = sum[prm_pkg::RUN_W] ? '1 : sum[prm_pkg::RUN_W-1:0];   // saturate
      end else begin
         if (run_ticks != '0)
            close_run();
         run_level = level;
         run_ticks = prm_pkg::RUN_W'(ticks);
      end
   endtask

   // Work out every result one accepted item causes, in output order.
   task automatic merge_item(input halves_item_type it);
      pulse_type idle_res;
      merge_half(it.first_level, it.first_ticks);
      merge_half(it.second_level, it.second_ticks);
      if (it.end_of_buffer) begin
         if (run_ticks != '0)
            close_run();
         // idle tail only for a buffer that produced something; never inverted
         if (buffer_emitted) begin
            idle_res.pulse_us   = 32'd0 - 32'(cfg_idle_us);
            idle_res.frame_done = 1'b1;
            expected_pulses.insert(expected_pulses.size(), idle_res);
         end
         run_level      = 1'b0;
         run_ticks      = '0;
         buffer_emitted = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Item driver: predicts on each transfer, then offers the next item or idles
   // ---------------------------------------------------------------------------------
   halves_item_type item_on_bus;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid         <= 1'b0;
         req_if.first_level   <= 1'b0;
         req_if.first_ticks   <= '0;
         req_if.second_level  <= 1'b0;
         req_if.second_ticks  <= '0;
         req_if.end_of_buffer <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            merge_item(item_on_bus);
         if (!req_if.valid || req_if.ready) begin
            if (item_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               item_on_bus                = item_backlog.pop_front();
               req_if.first_level   <= item_on_bus.first_level;
               req_if.first_ticks   <= item_on_bus.first_ticks;
               req_if.second_level  <= item_on_bus.second_level;
               req_if.second_ticks  <= item_on_bus.second_ticks;
               req_if.end_of_buffer <= item_on_bus.end_of_buffer;
               req_if.valid         <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Result receiver: random stalls, plus one long hold-off counted here
   // ---------------------------------------------------------------------------------
   int   hold_count = 0;
   logic hold_done  = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         // sender keeps offering; the output register and sequencer back up
         rsp_if.ready <= 1'b0;
         hold_count   <= hold_count + 1;
         if (hold_count == HOLD_CYCLES - 1)
            hold_done <= 1'b1;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------------------
   // Result checker: each transfer against the oldest prediction
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      pulse_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_pulses.size() == 0) begin
            $error("unexpected result: pulse_us=%0d frame_done=%0b",
                   rsp_if.pulse_us, rsp_if.frame_done);
            mismatch_count++;
         end else begin
            want = expected_pulses.pop_front();
            if (rsp_if.pulse_us !== want.pulse_us) begin
               $error("pulse_us: expected %0d, got %0d", want.pulse_us, rsp_if.pulse_us);
               mismatch_count++;
            end
            if (rsp_if.frame_done !== want.frame_done) begin
               $error("frame_done: expected %0b, got %0b", want.frame_done, rsp_if.frame_done);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("pulse_run_merger_core regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequence helpers
   // ---------------------------------------------------------------------------------

   // setup cycle, then access cycle; the register takes the value when pready is seen
   task automatic csr_write(input logic [1:0] index, input logic [prm_pkg::DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= prm_pkg::ADDR_W'({index, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         prm_pkg::REG_TICKS:    cfg_ticks_per_ten_us = value[prm_pkg::DIVS_W-1:0];
         prm_pkg::REG_INVERTED: cfg_inverted         = value[0];
         prm_pkg::REG_IDLE:     cfg_idle_us          = value[prm_pkg::IDLE_W-1:0];
         default: ;                         // unmapped: dropped
      endcase
   endtask

   task automatic set_traffic(input int idle_pct, input int stall_pct);
      @(negedge clock);
      sender_idle_pct = idle_pct;
      recv_stall_pct  = stall_pct;
   endtask

   // all items taken, all results in, then let a result-less item finish
   task automatic wait_idle();
      do @(negedge clock);
      while (item_backlog.size() != 0 || req_if.valid || expected_pulses.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic queue_item(input logic fl, input prm_pkg::ticks_type ft, input logic sl,
                             input prm_pkg::ticks_type st, input logic eob);
      halves_item_type it;
      it.first_level   = fl;
      it.first_ticks   = ft;
      it.second_level  = sl;
      it.second_ticks  = st;
      it.end_of_buffer = eob;
      item_backlog.insert(item_backlog.size(), it);
   endtask

   // short pulses and values of any size, with absent halves and full-scale values mixed in
   function automatic prm_pkg::ticks_type random_ticks();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         return '0;
      else if (pick < 15)
         return TICKS_MAX;
      else if (pick < 60)
         return prm_pkg::ticks_type'($urandom_range(1, 400));
      else
         return prm_pkg::ticks_type'($urandom_range(0, 32767));
   endfunction

   // Buffers of 1..8 items with alternating levels, as a receiver delivers them;
   // about one item in seven is pure noise (any levels, any end-of-buffer flag).
   task automatic queue_random_buffers(input int count);
      int              left;
      int              len;
      logic            level;
      halves_item_type it;
      left = count;
      while (left > 0) begin
         len = $urandom_range(1, 8);
         if (len > left)
            len = left;
         level = 1'($urandom_range(0, 1));
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 15) begin
               it.first_level   = 1'($urandom_range(0, 1));
               it.first_ticks   = prm_pkg::ticks_type'($urandom());
               it.second_level  = 1'($urandom_range(0, 1));
               it.second_ticks  = prm_pkg::ticks_type'($urandom());
               it.end_of_buffer = 1'($urandom_range(0, 1));
            end else begin
               it.first_level   = level;
               it.first_ticks   = random_ticks();
               it.second_level  = ($urandom_range(0, 99) < 85) ? ~level : level;
               it.second_ticks  = random_ticks();
               it.end_of_buffer = (k == len - 1);
               level            = ~it.second_level;
            end
            item_backlog.insert(item_backlog.size(), it);
         end
         left -= len;
      end
   endtask

   // one long high run of full-scale halves, left open
   task automatic queue_long_run(input int count);
      for (int k = 0; k < count; k++)
         queue_item(1'b1, TICKS_MAX, 1'b1, TICKS_MAX, 1'b0);
   endtask

   // ---------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed, on reset register values (10 ticks per 10 us, not inverted, 10000 us idle).
      set_traffic(0, 0);
      queue_item(1'b0, '0, 1'b0, '0, 1'b1);              // empty buffer: no idle tail
      queue_item(1'b1, '0, 1'b0, '0, 1'b1);              // only absent halves
      queue_item(1'b1, 15'd100, 1'b0, 15'd50, 1'b0);     // high run closed by low half
      queue_item(1'b0, 15'd25, 1'b1, TICKS_MAX, 1'b0);   // low grows, closed by high
      queue_item(1'b1, TICKS_MAX, 1'b1, TICKS_MAX, 1'b0);
      queue_item(1'b0, '0, 1'b1, 15'd1, 1'b0);           // absent first half skipped
      queue_item(1'b1, '0, 1'b0, '0, 1'b1);              // flush high run, idle tail
      queue_item(1'b0, 15'd7, 1'b0, '0, 1'b1);           // low run from fresh state
      queue_item(1'b1, 15'd3, 1'b0, '0, 1'b0);
      queue_item(1'b0, '0, 1'b1, 15'd4, 1'b1);           // merges across items
      queue_item(1'b0, 15'd1, 1'b1, 15'd1, 1'b1);        // shortest runs, two results + idle
      queue_item(1'b1, 15'd9, 1'b0, 15'd9, 1'b0);        // 9 us runs after scaling
      queue_item(1'b1, 15'd9, 1'b1, '0, 1'b1);           // closes one run and flushes: 3 results
      queue_item(1'b0, TICKS_MAX, 1'b1, TICKS_MAX, 1'b1);
      wait_idle();

      // Slowest tick rate, widest idle gap, no idling.
      csr_write(prm_pkg::REG_TICKS, 32'd1);
      csr_write(prm_pkg::REG_INVERTED, 32'd0);
      csr_write(prm_pkg::REG_IDLE, 32'd65535);
      set_traffic(0, 0);
      queue_random_buffers(60);
      wait_idle();

      // High tick rate, inverted pin, zero idle gap; sender mostly idle.
      csr_write(prm_pkg::REG_TICKS, 32'd800);
      csr_write(prm_pkg::REG_INVERTED, 32'd1);
      csr_write(prm_pkg::REG_IDLE, 32'd0);
      set_traffic(71, 0);
      queue_random_buffers(60);
      wait_idle();

      // Odd divisor, unmapped write must leave things alone; receiver mostly stalling.
      csr_write(prm_pkg::REG_TICKS, 32'd7);
      csr_write(prm_pkg::REG_IDLE, 32'($urandom_range(0, 65535)));
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      set_traffic(0, 71);
      queue_random_buffers(60);
      wait_idle();

      // Zero divisor (treated as one), junk in unused data bits, light idling on both
      // sides and a long receiver hold-off at the start so the block backs up.
      csr_write(prm_pkg::REG_TICKS, 32'hFFFF_FC00);
      csr_write(prm_pkg::REG_INVERTED, 32'hFFFF_FFFE);
      csr_write(prm_pkg::REG_IDLE, 32'd12345);
      set_traffic(13, 13);
      hold_go = 1'b1;
      queue_random_buffers(80);
      wait_idle();

      // Random settings, no idling.
      csr_write(prm_pkg::REG_TICKS, 32'($urandom_range(1, 800)));
      csr_write(prm_pkg::REG_INVERTED, 32'($urandom_range(0, 1)));
      csr_write(prm_pkg::REG_IDLE, 32'($urandom_range(0, 65535)));
      set_traffic(0, 0);
      queue_random_buffers(70);
      wait_idle();

      // Long run merged over many full-scale items, inverted, then closed by a short low run that is flushed.
      csr_write(prm_pkg::REG_TICKS, 32'd1);
      csr_write(prm_pkg::REG_INVERTED, 32'd1);
      queue_long_run(10);
      queue_item(1'b0, 15'd5, 1'b0, '0, 1'b1);
      wait_idle();

      if (expected_pulses.size() != 0) begin
         $error("%0d predicted results never arrived", expected_pulses.size());
         mismatch_count++;
      end

      if (mismatch_count == 0)
         $display("pulse_run_merger_core regression: pass");
      else
         $display("pulse_run_merger_core regression: fail");
      $finish;
   end

endmodule

### pulse_run_merger_core.f
+incdir+hw/rtl
hw/rtl/prm_pkg.sv
hw/rtl/prm_channels_if.sv
hw/rtl/prm_csr.sv
hw/rtl/prm_div.sv
hw/rtl/pulse_run_merger_core.sv
verif/tb_pulse_run_merger_core.sv
